/* rtl/md5_pkg.sv */
// Shared types, constants and round tables for the MD5 digest block.
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } md5_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       absorb;     // write the accepted byte, advance the bit count
        logic       load;       // copy chaining words into the working registers
        logic       round;      // run one compression round
        logic [5:0] round_idx;  // index of that round
        logic       add;        // fold working registers into the chaining words
        logic       pad;        // write 0x80 at the fill level, zeros above it
        logic       len;        // write the bit length into words 14 and 15
        logic       len_zero;   // also clear words 0 to 13
        logic       restart;    // return to the initial vector
        logic [1:0] word_sel;   // chaining word shown on the output
    } md5_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pos_last;         // fill level is byte 63
        logic pos_ge56;         // fill level is byte 56 or higher
    } md5_sts_t;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [3:0] sel);
        logic [4:0] s;
        case (sel)
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

/* rtl/md5_ctrl.sv */
// Controller state machine: sequences absorb, padding, compression and digest output.
module md5_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              byte_present,
    input  logic              message_end,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [1:0]        word_cnt,
    output md5_pkg::md5_cmd_t cmd,
    input  md5_pkg::md5_sts_t sts
);
    import md5_pkg::*;

    md5_state_t state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic [1:0] wcnt_reg, wcnt_next;
    logic       endp_reg, endp_next;
    logic       lenp_reg, lenp_next;
    logic       final_reg, final_next;
    logic       accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    // Next state and sequencing flags.
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        wcnt_next  = wcnt_reg;
        endp_next  = endp_reg;
        lenp_next  = lenp_reg;
        final_next = final_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present && sts.pos_last)
                    begin
                        state_next = ST_LOAD;
                        endp_next  = message_end;
                    end
                    else if (message_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
                round_next = '0;
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (final_reg)
                begin
                    state_next = ST_OUT;
                    wcnt_next  = '0;
                end
                else if (endp_reg)
                begin
                    state_next = ST_PAD;
                end
                else if (lenp_reg)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                endp_next = 1'b0;
                if (sts.pos_ge56)
                begin
                    lenp_next  = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                lenp_next  = 1'b0;
                final_next = 1'b1;
                state_next = ST_LOAD;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    wcnt_next = wcnt_reg + 2'd1;
                    if (wcnt_reg == 2'd3)
                    begin
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.absorb    = accept && byte_present;
        cmd.load      = (state_reg == ST_LOAD);
        cmd.round     = (state_reg == ST_ROUND);
        cmd.round_idx = round_reg;
        cmd.add       = (state_reg == ST_ADD);
        cmd.pad       = (state_reg == ST_PAD);
        cmd.len       = (state_reg == ST_LEN);
        cmd.len_zero  = lenp_reg;
        cmd.restart   = (state_reg == ST_OUT) && m_tready && (wcnt_reg == 2'd3);
        cmd.word_sel  = wcnt_reg;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign word_cnt = wcnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            wcnt_reg  <= '0;
            endp_reg  <= 1'b0;
            lenp_reg  <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            wcnt_reg  <= wcnt_next;
            endp_reg  <= endp_next;
            lenp_reg  <= lenp_next;
            final_reg <= final_next;
        end
    end

endmodule

/* rtl/md5_dp.sv */
// Datapath: message block, bit counter, chaining words and the round unit.
module md5_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  md5_pkg::md5_cmd_t cmd,
    output md5_pkg::md5_sts_t sts,
    output logic [31:0]       digest_word
);
    import md5_pkg::*;

    logic [31:0] chain_reg [4];
    logic [31:0] block_reg [16];
    logic [63:0] bit_total_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  pos;
    logic [1:0]  rnd;
    logic [3:0]  g;
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] b_new;

    assign pos          = bit_total_reg[8:3];
    assign sts.pos_last = (pos == 6'd63);
    assign sts.pos_ge56 = (pos[5:3] == 3'b111);
    assign digest_word  = chain_reg[cmd.word_sel];

    // One MD5 round: mixing function, message word select, rotate and add.
    assign rnd = cmd.round_idx[5:4];
    always_comb
    begin
        case (rnd)
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = cmd.round_idx[3:0];
            end
            2'd1:
            begin
                f = (b_reg & d_reg) | (c_reg & ~d_reg);
                g = 4'((cmd.round_idx[3:0] << 2) + cmd.round_idx[3:0] + 4'd1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'((cmd.round_idx[3:0] << 1) + cmd.round_idx[3:0] + 4'd5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'((cmd.round_idx[3:0] << 3) - cmd.round_idx[3:0]);
            end
        endcase
    end

    assign sum      = a_reg + f + round_const(cmd.round_idx) + block_reg[g];
    assign rot_wide = {sum, sum} << rot_amount({rnd, cmd.round_idx[1:0]});
    assign b_new    = b_reg + rot_wide[63:32];

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (cmd.round)
        begin
            a_reg <= d_reg;
            b_reg <= b_new;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    // Chaining words and bit counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0]  <= IV0;
            chain_reg[1]  <= IV1;
            chain_reg[2]  <= IV2;
            chain_reg[3]  <= IV3;
            bit_total_reg <= '0;
        end
        else if (cmd.restart)
        begin
            chain_reg[0]  <= IV0;
            chain_reg[1]  <= IV1;
            chain_reg[2]  <= IV2;
            chain_reg[3]  <= IV3;
            bit_total_reg <= '0;
        end
        else
        begin
            if (cmd.add)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
            if (cmd.absorb)
            begin
                bit_total_reg <= bit_total_reg + 64'd8;
            end
        end
    end

    // Message block: byte writes, padding and the length words.
    always_ff @(posedge clk)
    begin
        if (cmd.absorb)
        begin
            block_reg[pos[5:2]][8*pos[1:0] +: 8] <= data_byte;
        end
        else if (cmd.pad)
        begin
            for (int w = 0; w < 16; w++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    if (6'(4 * w + j) == pos)
                    begin
                        block_reg[w][8*j +: 8] <= 8'h80;
                    end
                    else if (6'(4 * w + j) > pos)
                    begin
                        block_reg[w][8*j +: 8] <= 8'h00;
                    end
                end
            end
        end
        else if (cmd.len)
        begin
            if (cmd.len_zero)
            begin
                for (int w = 0; w < 14; w++)
                begin
                    block_reg[w] <= '0;
                end
            end
            block_reg[14] <= bit_total_reg[31:0];
            block_reg[15] <= bit_total_reg[63:32];
        end
    end

endmodule

/* rtl/md5_message_digest.sv */
// Top level of the MD5 digest block: controller, datapath and assertions.
//
// Input channel s_*: one item per message byte. s_tdata carries the byte,
// s_tuser says whether a byte is present, s_tlast ends the message. An item
// with s_tuser low and s_tlast high ends the message without adding a byte.
// Output channel m_*: four items per message, the chaining words of the
// digest, word 0 first; m_tuser numbers them and m_tlast marks word 3.
//
// Items are taken one at a time. A byte that does not fill a block and does
// not end the message leaves the block ready for the next item. The byte
// that fills a block starts a compression (a load, 64 rounds on one round
// unit, a final add) before the next item is taken. Message end adds a pad
// step, a length step and one or two compressions, then presents the four
// words. The output waits for m_tready without losing data; no new item is
// taken until the last word leaves. Reset loads the initial vector and
// clears the bit count; the block is ready as soon as reset is released.
module md5_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // message_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [1:0]  m_tuser,   // [1:0] word_number
    output logic        m_tlast    // final_word
);
    import md5_pkg::*;

    md5_cmd_t   cmd;
    md5_sts_t   sts;
    logic [1:0] word_cnt;

    md5_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .byte_present (s_tuser),
        .message_end  (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .word_cnt     (word_cnt),
        .cmd          (cmd),
        .sts          (sts)
    );

    md5_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .digest_word (m_tdata)
    );

    assign m_tuser = word_cnt;
    assign m_tlast = (word_cnt == 2'd3);

`ifndef SYNTHESIS
    // Input and output are never open at the same time.
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input ready while digest is being delivered");

    // After the last word leaves, the block takes input again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block did not return to idle after the last word");

    // A stalled output word keeps its number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)))
        else $error("word number changed under stall");
`endif

endmodule
